### rtl/sprm_pkg.sv
// ----------------------------------------------------------------------------
// sprm_pkg: shared types and constants for the string-to-port/remote mapper
// Holds widths, register indexes, the sequencer state and the mapping mode.
// ----------------------------------------------------------------------------
package sprm_pkg;

   // Outputs per remote group and the highest string number served
   localparam int PortsPerRemote = 4;
   localparam int MaxStrings     = 256;

   // Field widths
   localparam int BasePortW    = 8;
   localparam int FirstRemoteW = 4;
   localparam int DepthW       = 5;
   localparam int StringW      = 9;
   localparam int PortW        = 9;
   localparam int RemoteW      = 5;
   localparam int OffsetW      = 8;
   localparam int CsrIndexW    = 2;
   localparam int CsrDataW     = 8;

   // Configuration register indexes
   localparam logic [CsrIndexW-1:0] CSR_BASE_PORT       = 2'd0;
   localparam logic [CsrIndexW-1:0] CSR_FIRST_REMOTE    = 2'd1;
   localparam logic [CsrIndexW-1:0] CSR_CASCADE_DEPTH   = 2'd2;
   localparam logic [CsrIndexW-1:0] CSR_CASCADE_ON_PORT = 2'd3;

   // Sequencer state
   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   // Step rule applied on every walk step
   typedef enum logic [1:0] {
      MODE_FLAT,
      MODE_CASCADE,
      MODE_WALK
   } mode_type;

endpackage

### rtl/string_to_port_remote_map_core.sv
// ----------------------------------------------------------------------------
// string_to_port_remote_map_core: locate a string on a controller
// Maps a one-based string number to its output port and remote index.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : configuration writes (base port, first remote, cascade depth,
//            cascade mode); always ready, write only while the block is idle.
//   req_*  : one beat carries a string number; taken only while the
//            sequencer is idle.
//   rsp_*  : one beat per request with the port and remote index.
// Walk: the sequencer takes s steps from request beat to result beat, s being the string
//   number minus one after saturation to 1..256 (0 when no base port is set).
//   One request is in work at a time; each step of the string walk passes once
//   through the shared step unit's incrementers and compares.
// The next request beat is taken only once the last result is loaded.
// The result sits in an output register, so the next request is taken while
//   a result still waits. A stalled receiver holds the result and, once a new
//   walk finishes, holds the sequencer until the register frees.
// Reset (synchronous, active high) clears the sequencer and the output valid
//   and loads base port 0, first remote 0, cascade depth 1, port walk mode.
// ----------------------------------------------------------------------------
module string_to_port_remote_map_core (
   input  logic                              clock,
   input  logic                              reset,
   // configuration port
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sprm_pkg::CsrIndexW-1:0]    csr_index,
   input  logic [sprm_pkg::CsrDataW-1:0]     csr_wdata,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sprm_pkg::StringW-1:0]      req_string_number,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sprm_pkg::PortW-1:0]        rsp_out_port,
   output logic [sprm_pkg::RemoteW-1:0]      rsp_out_remote
);

   // Configuration registers
   logic [sprm_pkg::BasePortW-1:0]    base_port_ff;
   logic [sprm_pkg::FirstRemoteW-1:0] first_remote_ff;
   logic [sprm_pkg::DepthW-1:0]       cascade_depth_ff;
   logic                              cascade_on_port_ff;

   // Sequencer and working registers
   sprm_pkg::state_type               state_ff, state_in;
   sprm_pkg::mode_type                mode_ff, mode_in;
   logic [sprm_pkg::OffsetW-1:0]      count_ff, count_in;
   logic [sprm_pkg::PortW-1:0]        port_ff, port_in;
   logic [sprm_pkg::RemoteW-1:0]      rel_ff, rel_in;

   // Output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sprm_pkg::PortW-1:0]        rsp_port_ff, rsp_port_in;
   logic [sprm_pkg::RemoteW-1:0]      rsp_remote_ff, rsp_remote_in;

   // Shared step unit signals
   logic [sprm_pkg::DepthW-1:0]       depth_eff;
   logic [sprm_pkg::PortW-1:0]        port_inc;
   logic [sprm_pkg::RemoteW-1:0]      rel_inc;
   logic                              rel_wrap;
   logic                              group_end;
   logic [sprm_pkg::StringW-1:0]      num_sat;
   logic [sprm_pkg::OffsetW-1:0]      offset;
   logic                              req_beat;
   logic                              rsp_free;

   assign csr_ready      = 1'b1;
   assign req_ready      = (state_ff == sprm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_port   = rsp_port_ff;
   assign rsp_out_remote = rsp_remote_ff;

   assign req_beat = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Clamp the string number and form the zero-based offset
   always_comb begin
      if (req_string_number == '0) begin
         num_sat = sprm_pkg::StringW'(1);
      end else if (req_string_number > sprm_pkg::StringW'(sprm_pkg::MaxStrings)) begin
         num_sat = sprm_pkg::StringW'(sprm_pkg::MaxStrings);
      end else begin
         num_sat = req_string_number;
      end
      offset = sprm_pkg::OffsetW'(num_sat - sprm_pkg::StringW'(1));
   end

   // Shared step unit: one port increment, one remote increment, a depth compare and a group-end compare
   assign depth_eff = (cascade_depth_ff == '0) ? sprm_pkg::DepthW'(1) : cascade_depth_ff;
   assign port_inc  = port_ff + sprm_pkg::PortW'(1);
   assign rel_inc   = rel_ff + sprm_pkg::RemoteW'(1);
   assign rel_wrap  = rel_inc >= depth_eff;
   assign group_end = ((port_ff - sprm_pkg::PortW'(1))
                       % sprm_pkg::PortW'(sprm_pkg::PortsPerRemote))
                      == sprm_pkg::PortW'(sprm_pkg::PortsPerRemote - 1);

   // Next state, step and output register loading
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      port_in       = port_ff;
      rel_in        = rel_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_port_in   = rsp_port_ff;
      rsp_remote_in = rsp_remote_ff;

      unique case (state_ff)
         sprm_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = sprm_pkg::ST_RUN;
               port_in  = sprm_pkg::PortW'(base_port_ff);
               rel_in   = '0;
               count_in = (base_port_ff == '0) ? '0 : offset;
               if (first_remote_ff == '0) begin
                  mode_in = sprm_pkg::MODE_FLAT;
               end else if (cascade_on_port_ff) begin
                  mode_in = sprm_pkg::MODE_CASCADE;
               end else begin
                  mode_in = sprm_pkg::MODE_WALK;
               end
            end
         end
         sprm_pkg::ST_RUN: begin
            if (count_ff != '0) begin
               // advance one string
               count_in = count_ff - sprm_pkg::OffsetW'(1);
               unique case (mode_ff)
                  sprm_pkg::MODE_FLAT: begin
                     port_in = port_inc;
                  end
                  sprm_pkg::MODE_CASCADE: begin
                     if (rel_wrap) begin
                        rel_in  = '0;
                        port_in = port_inc;
                     end else begin
                        rel_in  = rel_inc;
                     end
                  end
                  sprm_pkg::MODE_WALK: begin
                     if (!group_end) begin
                        port_in = port_inc;
                     end else if (rel_wrap) begin
                        rel_in  = '0;
                        port_in = port_inc;
                     end else begin
                        // back to the first port of this group, next remote
                        rel_in  = rel_inc;
                        port_in = port_ff - sprm_pkg::PortW'(sprm_pkg::PortsPerRemote - 1);
                     end
                  end
                  default: begin
                     port_in = port_ff;
                  end
               endcase
            end else if (rsp_free) begin
               // hand the result to the output register
               state_in      = sprm_pkg::ST_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_port_in   = port_ff;
               rsp_remote_in = sprm_pkg::RemoteW'(first_remote_ff) + rel_ff;
            end
         end
         default: begin
            state_in = sprm_pkg::ST_IDLE;
         end
      endcase
   end

   // State and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sprm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      count_ff      <= count_in;
      port_ff       <= port_in;
      rel_ff        <= rel_in;
      rsp_port_ff   <= rsp_port_in;
      rsp_remote_ff <= rsp_remote_in;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_port_ff       <= '0;
         first_remote_ff    <= '0;
         cascade_depth_ff   <= sprm_pkg::DepthW'(1);
         cascade_on_port_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sprm_pkg::CSR_BASE_PORT: begin
               base_port_ff <= csr_wdata[sprm_pkg::BasePortW-1:0];
            end
            sprm_pkg::CSR_FIRST_REMOTE: begin
               first_remote_ff <= csr_wdata[sprm_pkg::FirstRemoteW-1:0];
            end
            sprm_pkg::CSR_CASCADE_DEPTH: begin
               cascade_depth_ff <= csr_wdata[sprm_pkg::DepthW-1:0];
            end
            sprm_pkg::CSR_CASCADE_ON_PORT: begin
               cascade_on_port_ff <= csr_wdata[0];
            end
            default: begin
               cascade_on_port_ff <= cascade_on_port_ff;
            end
         endcase
      end
   end

`ifndef SYNTH
   // The remote offset never reaches the cascade depth during a walk
   a_rel_below_depth: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sprm_pkg::ST_RUN) |-> (rel_ff < depth_eff))
      else $error("remote offset reached cascade depth");

   // Without a remote the offset stays zero
   a_flat_no_remote: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sprm_pkg::ST_RUN && mode_ff == sprm_pkg::MODE_FLAT) |-> (rel_ff == '0))
      else $error("remote offset moved in flat mode");

   // Each step consumes exactly one string
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sprm_pkg::ST_RUN && count_ff != '0)
      |=> (state_ff == sprm_pkg::ST_RUN && count_ff == $past(count_ff) - sprm_pkg::OffsetW'(1)))
      else $error("walk step count broken");

   // A result is loaded only when the walk has finished
   a_load_when_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sprm_pkg::ST_RUN && state_in == sprm_pkg::ST_IDLE)
      |-> (count_ff == '0 && rsp_free))
      else $error("result loaded early or over a pending result");
`endif

endmodule

### verif/string_to_port_remote_map_core_tb.sv
// ----------------------------------------------------------------------------
// string_to_port_remote_map_core_tb: self-checking bench for the string mapper
// Sends string numbers through the request channel under a range of register
// settings, predicts each port/remote pair in a scoreboard and compares every
// result beat in order. The sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module string_to_port_remote_map_core_tb;

   localparam int ClockHalf   = 5;
   localparam int ResetCycles = 6;
   localparam int LimitCycles = 1_500_000;
   localparam int DrainCycles = 260;
   localparam int Phases      = 12;
   localparam int PhaseItems  = 100;

   typedef enum int {
      RX_OPEN,
      RX_CHOPPY,
      RX_BURSTY
   } rx_pattern_type;

   typedef struct packed {
      logic [sprm_pkg::PortW-1:0]   port;
      logic [sprm_pkg::RemoteW-1:0] remote;
   } location_type;

   // Predict the port and remote of each string and hold them until checked
   class location_scoreboard;
      logic [sprm_pkg::BasePortW-1:0]    cfg_base;
      logic [sprm_pkg::FirstRemoteW-1:0] cfg_first_remote;
      logic [sprm_pkg::DepthW-1:0]       cfg_depth;
      logic                              cfg_on_port;
      location_type                      expected_locations[$];
      int                                mismatches;

      function new();
         cfg_base         = '0;
         cfg_first_remote = '0;
         cfg_depth        = sprm_pkg::DepthW'(1);
         cfg_on_port      = 1'b0;
         mismatches       = 0;
      endfunction

      function void write_reg(logic [sprm_pkg::CsrIndexW-1:0] idx,
                              logic [sprm_pkg::CsrDataW-1:0] data);
         case (idx)
            sprm_pkg::CSR_BASE_PORT:       cfg_base = data[sprm_pkg::BasePortW-1:0];
            sprm_pkg::CSR_FIRST_REMOTE:    cfg_first_remote = data[sprm_pkg::FirstRemoteW-1:0];
            sprm_pkg::CSR_CASCADE_DEPTH:   cfg_depth = data[sprm_pkg::DepthW-1:0];
            sprm_pkg::CSR_CASCADE_ON_PORT: cfg_on_port = data[0];
            default: ;
         endcase
      endfunction

      function int unsigned group_of(int unsigned p);
         return (p - 1) / sprm_pkg::PortsPerRemote;
      endfunction

      function location_type locate_string(logic [sprm_pkg::StringW-1:0] num_in);
         int unsigned  num;
         int unsigned  ofs;
         int unsigned  depth;
         int unsigned  port;
         int unsigned  remote;
         int unsigned  nxt;
         location_type loc;
         num = num_in;
         // Clamp the string number into 1..MaxStrings
         if (num == 0) num = 1;
         if (num > sprm_pkg::MaxStrings) num = sprm_pkg::MaxStrings;
         ofs    = num - 1;
         depth  = (cfg_depth == 0) ? 1 : cfg_depth;
         port   = cfg_base;
         remote = cfg_first_remote;
         if (cfg_base != 0 && ofs != 0) begin
            if (cfg_first_remote == 0) begin
               port = cfg_base + ofs;
            end else if (cfg_on_port) begin
               port   = cfg_base + ofs / depth;
               remote = cfg_first_remote + ofs % depth;
            end else begin
               // Walk ports in groups, folding back and bumping the remote
               for (int i = 0; i < ofs; i++) begin
                  nxt = port + 1;
                  if (group_of(nxt) != group_of(port)) begin
                     if (remote + 1 - cfg_first_remote >= depth) begin
                        remote = cfg_first_remote;
                        port   = nxt;
                     end else begin
                        remote = remote + 1;
                        port   = group_of(port) * sprm_pkg::PortsPerRemote + 1;
                     end
                  end else begin
                     port = nxt;
                  end
               end
            end
         end
         loc.port   = port[sprm_pkg::PortW-1:0];
         loc.remote = remote[sprm_pkg::RemoteW-1:0];
         return loc;
      endfunction

      function void note_string(logic [sprm_pkg::StringW-1:0] num);
         expected_locations.push_back(locate_string(num));
      endfunction

      function void check_location(logic [sprm_pkg::PortW-1:0] port,
                                   logic [sprm_pkg::RemoteW-1:0] remote);
         location_type exp_loc;
         if (expected_locations.size() == 0) begin
            $error("unexpected result beat: out_port %0d out_remote %0d", port, remote);
            mismatches++;
         end else begin
            exp_loc = expected_locations.pop_front();
            if (port !== exp_loc.port) begin
               $error("out_port mismatch: expected %0d, actual %0d", exp_loc.port, port);
               mismatches++;
            end
            if (remote !== exp_loc.remote) begin
               $error("out_remote mismatch: expected %0d, actual %0d", exp_loc.remote, remote);
               mismatches++;
            end
         end
      endfunction
   endclass

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_valid = 1'b0;
   logic                           csr_ready;
   logic [sprm_pkg::CsrIndexW-1:0] csr_index = sprm_pkg::CSR_BASE_PORT;
   logic [sprm_pkg::CsrDataW-1:0]  csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [sprm_pkg::StringW-1:0]   req_string_number = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [sprm_pkg::PortW-1:0]     rsp_out_port;
   logic [sprm_pkg::RemoteW-1:0]   rsp_out_remote;

   location_scoreboard   book = new();
   int                   strings_taken = 0;
   int                   writes_taken = 0;
   int                   cycle_count = 0;
   int                   hold_left = 0;
   rx_pattern_type       rx_pattern = RX_OPEN;

   string_to_port_remote_map_core u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_string_number (req_string_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_port      (rsp_out_port),
      .rsp_out_remote    (rsp_out_remote)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   // Sample every handshake at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            book.check_location(rsp_out_port, rsp_out_remote);
         end
         if (req_valid && req_ready) begin
            book.note_string(req_string_number);
            strings_taken++;
         end
         if (csr_valid && csr_ready) begin
            book.write_reg(csr_index, csr_wdata);
            writes_taken++;
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LimitCycles) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Stall the result channel on the current pattern
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_pattern)
            RX_CHOPPY: rsp_ready <= 1'($urandom_range(0, 1));
            RX_BURSTY: begin
               if ($urandom_range(0, 15) == 0) begin
                  hold_left <= $urandom_range(1, 24);
                  rsp_ready <= 1'b0;
               end else begin
                  rsp_ready <= 1'b1;
               end
            end
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   // All driver tasks start and return just after a falling edge

   task automatic write_csr(input logic [sprm_pkg::CsrIndexW-1:0] idx,
                            input logic [sprm_pkg::CsrDataW-1:0] data);
      int taken;
      taken = writes_taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(negedge clock); while (writes_taken == taken);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [7:0] base_w, input logic [7:0] first_w,
                            input logic [7:0] depth_w, input logic [7:0] mode_w);
      write_csr(sprm_pkg::CSR_BASE_PORT, base_w);
      write_csr(sprm_pkg::CSR_FIRST_REMOTE, first_w);
      write_csr(sprm_pkg::CSR_CASCADE_DEPTH, depth_w);
      write_csr(sprm_pkg::CSR_CASCADE_ON_PORT, mode_w);
   endtask

   task automatic send_string(input logic [sprm_pkg::StringW-1:0] num);
      int taken;
      taken = strings_taken;
      req_valid         <= 1'b1;
      req_string_number <= num;
      do @(negedge clock); while (strings_taken == taken);
   endtask

   // Drop valid and wait until every expected location has been checked
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (book.expected_locations.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic send_phase(input int count, input int gap_max);
      int                           left;
      int                           burst;
      int                           gap;
      logic [sprm_pkg::StringW-1:0] num;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 16);
         if (burst > left) burst = left;
         repeat (burst) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: num = sprm_pkg::StringW'($urandom_range(1, 12));
               4, 5:       num = sprm_pkg::StringW'($urandom_range(0, 511));
               6, 7:       num = sprm_pkg::StringW'($urandom_range(1, 256));
               8: begin
                  case ($urandom_range(0, 5))
                     0:       num = 0;
                     1:       num = 1;
                     2:       num = 2;
                     3:       num = 255;
                     4:       num = 256;
                     default: num = 511;
                  endcase
               end
               default:    num = sprm_pkg::StringW'($urandom_range(1, 64));
            endcase
            send_string(num);
         end
         left -= burst;
         // Idle between bursts
         if (gap_max > 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
      end
   endtask

   initial begin
      int         phase;
      logic [7:0] base_w;
      logic [7:0] first_w;
      logic [7:0] depth_w;

      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset values: no base port, so base values come back
      send_string(1);
      send_string(0);
      send_string(256);
      wait_drained();

      // No remote: port is base plus offset, string number saturates
      configure(8'd5, 8'd0, 8'd1, 8'd0);
      send_string(2);
      send_string(256);
      send_string(511);
      send_string(300);
      wait_drained();

      // Cascade on one port at the largest base and remote
      configure(8'd255, 8'd15, 8'd16, 8'd1);
      send_string(256);
      send_string(17);
      send_string(16);
      wait_drained();

      // Zero depth behaves as a depth of one
      write_csr(sprm_pkg::CSR_CASCADE_DEPTH, 8'd0);
      send_string(3);
      send_string(256);
      wait_drained();

      // Port group walk across group edges and depth wraps
      configure(8'd3, 8'd2, 8'd3, 8'd0);
      send_string(2);
      send_string(3);
      send_string(4);
      send_string(8);
      send_string(13);
      send_string(256);
      wait_drained();

      // Upper data bits are dropped; a deep cascade depth in walk mode wraps the remote field
      configure(8'hFF, 8'hFF, 8'hFF, 8'hFE);
      send_string(256);
      send_string(100);
      wait_drained();
      write_csr(sprm_pkg::CSR_BASE_PORT, 8'd1);
      send_string(256);
      send_string(200);
      wait_drained();

      // Random phases, each under its own register setting and idling mix
      for (phase = 0; phase < Phases; phase++) begin
         case ($urandom_range(0, 5))
            0:       base_w = 8'd0;
            1:       base_w = 8'd1;
            2:       base_w = 8'd255;
            5:       base_w = 8'($urandom_range(0, 255));
            default: base_w = 8'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 3))
            0:       first_w = 8'd0;
            1:       first_w = {4'($urandom_range(0, 15)), 4'hF};
            default: first_w = 8'($urandom_range(0, 255));
         endcase
         case ($urandom_range(0, 4))
            0:       depth_w = 8'd0;
            1:       depth_w = 8'd16;
            2:       depth_w = 8'($urandom_range(0, 255));
            default: depth_w = 8'($urandom_range(1, 6));
         endcase
         configure(base_w, first_w, depth_w, 8'($urandom_range(0, 255)));
         rx_pattern = rx_pattern_type'(phase % 3);
         send_phase(PhaseItems, (phase % 2 == 0) ? 0 : 8);
         wait_drained();
      end

      // Catch stray beats after the last result
      repeat (DrainCycles) @(negedge clock);
      if (book.mismatches == 0 && book.expected_locations.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
